### rtl/tlfc_pkg.sv
// Types and constants shared by the tank level fill controller.
package tlfc_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 16;
  localparam int ERR_W  = 5;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] DETECT_RST   = 16'd200;
  localparam logic [CNT_W-1:0] UNDETECT_RST = 16'd200;
  localparam logic [CNT_W-1:0] ADD_RST      = 16'd500;
  localparam logic [CNT_W-1:0] INITIAL_RST  = 16'd2500;

  // All five error bits set: the level actions are skipped
  localparam logic [ERR_W-1:0] ERR_ALL = 5'h1F;

  // Register index, taken from paddr word address
  typedef enum logic [2:0] {
    REG_DETECT   = 3'd0,
    REG_UNDETECT = 3'd1,
    REG_ADD      = 3'd2,
    REG_INITIAL  = 3'd3,
    REG_REQUEST  = 3'd4
  } tlfc_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] detect_ticks;
    logic [CNT_W-1:0] undetect_ticks;
    logic [CNT_W-1:0] add_water_ticks;
    logic [CNT_W-1:0] initial_fill_ticks;
    logic             initial_fill_request;
  } tlfc_cfg_t;

  typedef struct packed {
    logic             level;
    logic [CNT_W-1:0] on_count;
    logic [CNT_W-1:0] off_count;
    logic             add_armed;
    logic [CNT_W-1:0] add_count;
    logic             initial_pending;
    logic             initial_active;
    logic [CNT_W-1:0] initial_count;
  } tlfc_state_t;

  typedef struct packed {
    logic             power_on;
    logic             motor_starting;
    logic             reed_open;
    logic [ERR_W-1:0] error_flags;
    logic             setting_time_busy;
    logic             memento_display;
    logic             mode_wash;
    logic             motors_ended;
    logic             sterilizing;
    logic             nozzle_cleaning;
    logic             factory_test;
    logic             stop_error;
  } tlfc_in_t;

  typedef struct packed {
    logic valve_on;
    logic level_present;
    logic mode_stop;
    logic self_clean_cmd;
    logic electrolysis_stop;
    logic add_ready;
    logic initial_done;
  } tlfc_res_t;

endpackage

### rtl/tlfc_step.sv
// Per-tick update: initial fill, switch debounce, add-water countdown, level actions.
module tlfc_step (
  input  tlfc_pkg::tlfc_cfg_t   cfg,
  input  tlfc_pkg::tlfc_state_t state,
  input  tlfc_pkg::tlfc_in_t    tick,
  output tlfc_pkg::tlfc_state_t state_next,
  output tlfc_pkg::tlfc_res_t   res
);
  import tlfc_pkg::*;

  always_comb begin
    tlfc_state_t s;
    logic valve;
    logic mstop;
    logic sclean;
    logic estop;
    logic idone;
    s      = state;
    valve  = 1'b0;
    mstop  = 1'b0;
    sclean = 1'b0;
    estop  = 1'b0;
    idone  = 1'b0;

    if (tick.power_on) begin
      if (tick.motor_starting) begin
        // first motor start-up kicks off a pending initial fill
        if (s.initial_pending) begin
          s.initial_active = 1'b1;
        end
      end else if (s.initial_active) begin
        // one-time initial fill holds the valve open
        if (s.initial_count < cfg.initial_fill_ticks) begin
          s.initial_count = s.initial_count + 16'd1;
          valve = 1'b1;
        end else begin
          s.initial_pending = 1'b0;
          s.initial_active  = 1'b0;
          s.initial_count   = '0;
          idone = 1'b1;
        end
      end else begin
        // add-water countdown
        if (s.add_count != '0) begin
          s.add_count = s.add_count - 16'd1;
          valve = 1'b1;
        end

        // debounce: closed switch means water present
        if (!tick.reed_open) begin
          s.off_count = '0;
          if (s.on_count < cfg.detect_ticks) begin
            s.on_count = s.on_count + 16'd1;
          end else begin
            s.level = 1'b1;
          end
        end else begin
          s.on_count = '0;
          if (s.off_count < cfg.undetect_ticks) begin
            s.off_count = s.off_count + 16'd1;
          end else begin
            s.level = 1'b0;
          end
        end

        if (tick.error_flags != ERR_ALL) begin
          // level seen while armed: disarm and start the extra fill if none is running
          if (s.level && s.add_armed && !tick.setting_time_busy && !tick.memento_display) begin
            s.add_armed = 1'b0;
            if (s.add_count == '0) begin
              s.add_count = cfg.add_water_ticks;
            end
          end
          // level lost: stop and refill
          if (!s.level) begin
            if (tick.mode_wash) begin
              mstop = 1'b1;
            end else begin
              if (!s.add_armed) begin
                sclean = 1'b1;
              end
              if (tick.motors_ended && !tick.sterilizing && !tick.nozzle_cleaning &&
                  s.add_count == '0 && !tick.memento_display && !tick.factory_test &&
                  !tick.stop_error) begin
                valve = 1'b1;
              end
            end
            estop = 1'b1;
            s.add_armed = 1'b1;
          end
        end
      end
    end

    state_next            = s;
    res.valve_on          = valve;
    res.level_present     = s.level;
    res.mode_stop         = mstop;
    res.self_clean_cmd    = sclean;
    res.electrolysis_stop = estop;
    res.add_ready         = s.add_armed;
    res.initial_done      = idone;
  end

endmodule

### rtl/tank_level_fill_controller.sv
// Top level of the tank level fill controller: config port, state and result register.
// Latency: a tick transferred at one edge shows its result from the next cycle on.
// Throughput: one tick per cycle while results are taken; state updates in one pass
// per transfer unless an add/request write wins; the result register frees when taken.
// Reset (rst, synchronous): registers return to their defaults, state clears,
// add-water count loads 500, no result is held.
module tank_level_fill_controller (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlfc_pkg::ADDR_W-1:0] paddr,
  input  logic [tlfc_pkg::DATA_W-1:0] pwdata,
  output logic [tlfc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // tick input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        power_on,
  input  logic                        motor_starting,
  input  logic                        reed_open,
  input  logic [tlfc_pkg::ERR_W-1:0]  error_flags,
  input  logic                        setting_time_busy,
  input  logic                        memento_display,
  input  logic                        mode_wash,
  input  logic                        motors_ended,
  input  logic                        sterilizing,
  input  logic                        nozzle_cleaning,
  input  logic                        factory_test,
  input  logic                        stop_error,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        valve_on,
  output logic                        level_present,
  output logic                        mode_stop,
  output logic                        self_clean_cmd,
  output logic                        electrolysis_stop,
  output logic                        add_ready,
  output logic                        initial_done
);
  import tlfc_pkg::*;

  tlfc_cfg_t   cfg;
  tlfc_state_t state;
  tlfc_state_t state_next;
  tlfc_in_t    tick;
  tlfc_res_t   res_next;
  tlfc_res_t   res;
  tlfc_reg_t   reg_sel;
  logic        cfg_wr;
  logic        in_xfer;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = tlfc_reg_t'(paddr[ADDR_W-1:2]);

  // register read-back
  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_DETECT:   prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.detect_ticks};
      REG_UNDETECT: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.undetect_ticks};
      REG_ADD:      prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.add_water_ticks};
      REG_INITIAL:  prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.initial_fill_ticks};
      REG_REQUEST:  prdata = {{(DATA_W-1){1'b0}}, cfg.initial_fill_request};
      default:      prdata = '0;
    endcase
  end

  assign tick = '{
    power_on:          power_on,
    motor_starting:    motor_starting,
    reed_open:         reed_open,
    error_flags:       error_flags,
    setting_time_busy: setting_time_busy,
    memento_display:   memento_display,
    mode_wash:         mode_wash,
    motors_ended:      motors_ended,
    sterilizing:       sterilizing,
    nozzle_cleaning:   nozzle_cleaning,
    factory_test:      factory_test,
    stop_error:        stop_error
  };

  // input taken whenever the result register is empty or being emptied
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  tlfc_step u_step (
    .cfg        (cfg),
    .state      (state),
    .tick       (tick),
    .state_next (state_next),
    .res        (res_next)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_ticks         <= DETECT_RST;
      cfg.undetect_ticks       <= UNDETECT_RST;
      cfg.add_water_ticks      <= ADD_RST;
      cfg.initial_fill_ticks   <= INITIAL_RST;
      cfg.initial_fill_request <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DETECT:   cfg.detect_ticks         <= pwdata[CNT_W-1:0];
        REG_UNDETECT: cfg.undetect_ticks       <= pwdata[CNT_W-1:0];
        REG_ADD:      cfg.add_water_ticks      <= pwdata[CNT_W-1:0];
        REG_INITIAL:  cfg.initial_fill_ticks   <= pwdata[CNT_W-1:0];
        REG_REQUEST:  cfg.initial_fill_request <= pwdata[0];
        default:      ;
      endcase
    end
  end

  // controller state: a write to the add-water or request register also loads state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{
        level:           1'b0,
        on_count:        '0,
        off_count:       '0,
        add_armed:       1'b0,
        add_count:       ADD_RST,
        initial_pending: 1'b0,
        initial_active:  1'b0,
        initial_count:   '0
      };
    end else if (cfg_wr && reg_sel == REG_ADD) begin
      state.add_count <= pwdata[CNT_W-1:0];
    end else if (cfg_wr && reg_sel == REG_REQUEST) begin
      state.initial_pending <= pwdata[0];
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res <= res_next;
    end
  end

  assign valve_on          = res.valve_on;
  assign level_present     = res.level_present;
  assign mode_stop         = res.mode_stop;
  assign self_clean_cmd    = res.self_clean_cmd;
  assign electrolysis_stop = res.electrolysis_stop;
  assign add_ready         = res.add_ready;
  assign initial_done      = res.initial_done;

endmodule

### rtl/tlfc_checker.sv
// Port-level checks for the tank level fill controller, bound to the top level.
module tlfc_port_props (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic power_on,
  input logic out_valid,
  input logic out_ready,
  input logic valve_on,
  input logic level_present,
  input logic mode_stop,
  input logic self_clean_cmd,
  input logic electrolysis_stop,
  input logic add_ready,
  input logic initial_done
);

  // every tick transfer yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("tick transfer gave no result");

  // a tick with power off commands nothing
  a_power_off_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !power_on |=>
      !valve_on && !mode_stop && !self_clean_cmd && !electrolysis_stop && !initial_done)
    else $error("command issued on a power-off tick");

  // low-level strobes come with electrolysis stop, low level and add-water armed
  a_low_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode_stop || self_clean_cmd) |->
      electrolysis_stop && !level_present && add_ready)
    else $error("low-level strobe without matching state");

  // initial fill end is never mixed with level actions
  a_initial_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && initial_done |-> !valve_on && !electrolysis_stop)
    else $error("initial fill end mixed with other commands");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(valve_on) && $stable(level_present)
      && $stable(electrolysis_stop) && $stable(add_ready))
    else $error("stalled result changed");

endmodule

bind tank_level_fill_controller tlfc_port_props u_tlfc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .power_on          (power_on),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .valve_on          (valve_on),
  .level_present     (level_present),
  .mode_stop         (mode_stop),
  .self_clean_cmd    (self_clean_cmd),
  .electrolysis_stop (electrolysis_stop),
  .add_ready         (add_ready),
  .initial_done      (initial_done)
);
